>>> sv/ijh_pkg.sv
// Package for the interval jitter histogram block.
// Holds the histogram geometry, the nominal period at reset and the item kind codes.
// No dependencies.
package ijh_pkg;

	localparam int JITTER_BINS = 64;
	localparam int BIN_W = (JITTER_BINS > 1) ? $clog2(JITTER_BINS) : 1;

	localparam logic [31:0] NOMINAL_RESET = 32'd40000;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_READ = 1'b1;

endpackage

>>> sv/interval_jitter_histogram.sv
// Throughput: one word per cycle unless the output stalls; the histogram
//   read-modify-write forwards the value written in the cycle of the read, so
//   back-to-back hits on one bin work. The last stage feeds the result register.
// Reset (arst_n low, asynchronous): clears the pipeline, the previous-tick flag,
//   the maximum jitter, all histogram bins (through per-bin valid flags) and sets
//   nominal_period to 40000. No clearing pass; the block takes words right away.
// Top level of the interval jitter histogram; depends on ijh_pkg.
module interval_jitter_histogram
	import ijh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        nominal_period_wr,
	input  logic [31:0] nominal_period,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] timestamp,
	input  logic [5:0]  bin_index,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        jitter_valid,
	output logic [29:0] jitter,
	output logic [29:0] max_jitter,
	output logic [31:0] bin_count
);

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves together when the output
	// register is empty or being taken. Bubbles travel as cleared valids.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic adv;
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Control state
	logic [31:0]            nominal_q;
	logic                   have_prev_q;
	logic [29:0]            worst_q;
	logic [JITTER_BINS-1:0] hist_vld_q;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;

	// Payload registers
	logic [31:0]      prev_time_q;
	logic             kind_s1, kind_s2, kind_s3, kind_s4;
	logic [31:0]      ts_s1;
	logic [5:0]       idx_s1, idx_s2, idx_s3;
	logic             meas_s2, meas_s3, meas_s4;
	logic [31:0]      interval_s2;
	logic [31:0]      dev_s3;
	logic [29:0]      jit_s4;
	logic [BIN_W-1:0] addr_s4;
	logic             in_range_s4;
	logic [31:0]      rd_data_s4;
	logic             rd_vld_s4;
	logic             fwd_s4;
	logic [31:0]      wr_data_q;
	logic             jitter_valid_q;
	logic [29:0]      jitter_q;
	logic [29:0]      max_jitter_q;
	logic [31:0]      bin_count_q;

	// Histogram storage
	logic [31:0] hist_mem [JITTER_BINS];

	// ------------------------------------------------------------------
	// Stage 1: wrapped interval since the previous tick. The previous
	// timestamp is owned here, so ticks see it strictly in order.
	// ------------------------------------------------------------------
	logic        tick_s1;
	logic [31:0] interval_c;
	assign tick_s1    = vld_s1 && (kind_s1 == KIND_TICK);
	assign interval_c = ts_s1 - prev_time_q;

	// ------------------------------------------------------------------
	// Stage 2: absolute deviation from the nominal period.
	// ------------------------------------------------------------------
	logic [31:0] dev_c;
	always_comb begin
		if (interval_s2 > nominal_q) begin
			dev_c = interval_s2 - nominal_q;
		end else begin
			dev_c = nominal_q - interval_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: round to eighths, clamp to the last bin, issue the
	// histogram read (bin of a tick, or the requested bin of a read).
	// ------------------------------------------------------------------
	logic [32:0]      jit_sum_c;
	logic [29:0]      jit_c;
	logic [BIN_W-1:0] tick_bin_c;
	logic [BIN_W-1:0] rd_addr;
	logic             in_range_c;

	assign jit_sum_c  = {1'b0, dev_s3} + 33'd4;
	assign jit_c      = jit_sum_c[32:3];
	assign tick_bin_c = (jit_c >= 30'(JITTER_BINS)) ? BIN_W'(JITTER_BINS - 1)
	                                                 : jit_c[BIN_W-1:0];
	assign in_range_c = (32'(idx_s3) < 32'(JITTER_BINS));
	assign rd_addr    = (kind_s3 == KIND_READ) ? BIN_W'(idx_s3) : tick_bin_c;

	// ------------------------------------------------------------------
	// Stage 4: for a measured tick, increment the bin and write it back; track the maximum.
	// The write of the word ahead lands in the same cycle as this word's
	// read, so take its value from wr_data_q when the addresses matched.
	// A bin never written since reset reads as zero.
	// ------------------------------------------------------------------
	logic [31:0] base_c;
	logic [31:0] wr_data;
	logic        wr_en;
	logic [29:0] worst_nxt;

	always_comb begin
		if (fwd_s4) begin
			base_c = wr_data_q;
		end else if (rd_vld_s4) begin
			base_c = rd_data_s4;
		end else begin
			base_c = 32'd0;
		end
	end

	assign wr_data   = base_c + 32'd1;
	assign wr_en     = adv && vld_s4 && meas_s4;
	assign worst_nxt = (meas_s4 && (jit_s4 > worst_q)) ? jit_s4 : worst_q;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q   <= NOMINAL_RESET;
			have_prev_q <= 1'b0;
			worst_q     <= 30'd0;
			hist_vld_q  <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (nominal_period_wr) begin
				nominal_q <= nominal_period;
			end
			if (adv) begin
				vld_s1      <= in_valid;
				vld_s2      <= vld_s1;
				vld_s3      <= vld_s2;
				vld_s4      <= vld_s3;
				out_valid_q <= vld_s4;
				if (tick_s1) begin
					have_prev_q <= 1'b1;
				end
				if (vld_s4 && meas_s4) begin
					worst_q <= worst_nxt;
				end
			end
			if (wr_en) begin
				hist_vld_q[addr_s4] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: capture the input word
			kind_s1 <= kind;
			ts_s1   <= timestamp;
			idx_s1  <= bin_index;
			if (tick_s1) begin
				prev_time_q <= ts_s1;
			end

			// stage 2
			kind_s2     <= kind_s1;
			idx_s2      <= idx_s1;
			meas_s2     <= tick_s1 && have_prev_q;
			interval_s2 <= interval_c;

			// stage 3
			kind_s3 <= kind_s2;
			idx_s3  <= idx_s2;
			meas_s3 <= meas_s2;
			dev_s3  <= dev_c;

			// stage 4
			kind_s4     <= kind_s3;
			meas_s4     <= meas_s3;
			jit_s4      <= jit_c;
			addr_s4     <= rd_addr;
			in_range_s4 <= in_range_c;
			rd_data_s4  <= hist_mem[rd_addr];
			rd_vld_s4   <= hist_vld_q[rd_addr];
			fwd_s4      <= wr_en && (addr_s4 == rd_addr);

			// result register
			jitter_valid_q <= meas_s4;
			jitter_q       <= meas_s4 ? jit_s4 : 30'd0;
			max_jitter_q   <= worst_nxt;
			bin_count_q    <= ((kind_s4 == KIND_READ) && in_range_s4) ? base_c : 32'd0;
		end
		if (wr_en) begin
			hist_mem[addr_s4] <= wr_data;
			wr_data_q         <= wr_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign jitter_valid = jitter_valid_q;
	assign jitter       = jitter_q;
	assign max_jitter   = max_jitter_q;
	assign bin_count    = bin_count_q;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for interval_jitter_histogram, the tick interval jitter monitor.
// A built-in predictor tracks the previous tick, the worst jitter and the bins.
// Each result word is compared in order with the oldest expected reading. Depends on ijh_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ijh_pkg::*;

	localparam int HOLD_CYCLES  = 200;  // long receiver hold-off to back the block up
	localparam int SETTLE_EDGES = 8;    // time for the pipeline to empty, plus margin
	localparam int REPORT_CAP   = 60;   // stop printing after this many bad fields
	localparam int PHASE_WORDS  = 105;

	typedef struct packed {
		logic        kind;
		logic [31:0] timestamp;
		logic [5:0]  bin_index;
	} sample_t;

	typedef struct packed {
		logic        jitter_valid;
		logic [29:0] jitter;
		logic [29:0] max_jitter;
		logic [31:0] bin_count;
	} reading_t;

	typedef struct packed {
		sample_t  word;
		logic     checked;    // 1: compare against the reading typed in the row
		reading_t want;
	} opening_row_t;

	// DUT ports, inputs all known from time zero
	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        nominal_period_wr = 1'b0;
	logic [31:0] nominal_period    = 32'd0;
	logic        in_valid          = 1'b0;
	logic        in_stall;
	logic        kind              = KIND_TICK;
	logic [31:0] timestamp         = 32'd0;
	logic [5:0]  bin_index         = 6'd0;
	logic        out_valid;
	logic        out_stall         = 1'b0;
	logic        jitter_valid;
	logic [29:0] jitter;
	logic [29:0] max_jitter;
	logic [31:0] bin_count;

	// Shadow copy of the block's state and register
	logic [31:0] shadow_period;
	logic [31:0] shadow_prev_time;
	logic        shadow_seen_tick;
	logic [29:0] shadow_worst;
	logic [31:0] shadow_bins [JITTER_BINS];

	reading_t    awaited_readings [$];
	int unsigned fault_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_request   = 1'b0;
	logic        out_hold       = 1'b0;

	// Directed opening, run with the period at its reset value of 40000.
	// Checked rows can be read off by hand; the rest go through the predictor.
	localparam int OPENING_ROWS = 17;
	opening_row_t opening_rows [OPENING_ROWS] = '{
		// fresh out of reset: empty bins, no maximum yet
		'{'{KIND_READ, 32'h0000_0000, 6'd0},  1'b1, '{1'b0, 30'd0, 30'd0, 32'd0}},
		// timestamp ignored on reads, highest bin
		'{'{KIND_READ, 32'hFFFF_FFFF, 6'd63}, 1'b1, '{1'b0, 30'd0, 30'd0, 32'd0}},
		// first tick only records its time
		'{'{KIND_TICK, 32'd0,         6'd0},  1'b1, '{1'b0, 30'd0, 30'd0, 32'd0}},
		// exact period: zero jitter, bin index ignored on ticks
		'{'{KIND_TICK, 32'd40000,     6'd63}, 1'b1, '{1'b1, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_READ, 32'd0,         6'd0},  1'b1, '{1'b0, 30'd0, 30'd0, 32'd1}},
		// deviation 3 rounds down, 4 rounds up
		'{'{KIND_TICK, 32'd80003,     6'd0},  1'b1, '{1'b1, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_TICK, 32'd120007,    6'd0},  1'b1, '{1'b1, 30'd1, 30'd1, 32'd0}},
		// short interval, deviation 11
		'{'{KIND_TICK, 32'd159996,    6'd0},  1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_READ, 32'd0,         6'd1},  1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		// zero interval: jitter 5000 lands in the clamp bin
		'{'{KIND_TICK, 32'd159996,    6'd0},  1'b1, '{1'b1, 30'd5000, 30'd5000, 32'd0}},
		'{'{KIND_READ, 32'd0,         6'd63}, 1'b1, '{1'b0, 30'd0, 30'd5000, 32'd1}},
		// largest timestamp, then wrap back around to an exact period
		'{'{KIND_TICK, 32'hFFFF_FFFF, 6'd0},  1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_TICK, 32'd39999,     6'd0},  1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_TICK, 32'hAAAA_AAAA, 6'h2A}, 1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_TICK, 32'h5555_5555, 6'h15}, 1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_READ, 32'h5555_5555, 6'h2A}, 1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}},
		'{'{KIND_READ, 32'hAAAA_AAAA, 6'h15}, 1'b0, '{1'b0, 30'd0, 30'd0, 32'd0}}
	};

	interval_jitter_histogram dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.nominal_period_wr (nominal_period_wr),
		.nominal_period    (nominal_period),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.timestamp         (timestamp),
		.bin_index         (bin_index),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.jitter_valid      (jitter_valid),
		.jitter            (jitter),
		.max_jitter        (max_jitter),
		.bin_count         (bin_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the shadow state by one accepted word and return its reading.
	function automatic reading_t predict_reading(sample_t w);
		reading_t    r;
		logic [31:0] span;
		logic [32:0] deviation;
		logic [29:0] rounded;
		int unsigned slot;
		r = '0;
		if (w.kind == KIND_READ) begin
			if (int'(w.bin_index) < JITTER_BINS)
				r.bin_count = shadow_bins[w.bin_index];
		end else begin
			if (shadow_seen_tick) begin
				// interval wraps modulo 2^32 by plain unsigned subtraction
				span = w.timestamp - shadow_prev_time;
				deviation = (span > shadow_period) ? {1'b0, span - shadow_period}
				                                   : {1'b0, shadow_period - span};
				// round to nearest eighth; the top case is exactly 2^29
				rounded = 30'((deviation + 33'd4) >> 3);
				if (rounded > shadow_worst)
					shadow_worst = rounded;
				slot = (rounded >= JITTER_BINS) ? JITTER_BINS - 1 : rounded;
				shadow_bins[slot] = shadow_bins[slot] + 32'd1;
				r.jitter_valid = 1'b1;
				r.jitter = rounded;
			end
			shadow_seen_tick = 1'b1;
			shadow_prev_time = w.timestamp;
		end
		r.max_jitter = shadow_worst;
		return r;
	endfunction

	// Draw one random word. Most are ticks spaced near the period, so the jitter
	// spreads over the low bins and past the clamp; some intervals are wild.
	function automatic sample_t pick_word();
		sample_t     w;
		logic [31:0] span;
		int          offset;
		w.timestamp = $urandom;
		w.bin_index = 6'($urandom_range(63));
		if ($urandom_range(3) == 0) begin
			w.kind = KIND_READ;
		end else begin
			w.kind = KIND_TICK;
			offset = int'($urandom_range(1120)) - 560;
			case ($urandom_range(19))
				0: begin
					span = 32'd0;
				end
				1: begin
					span = 32'hFFFF_FFFF;
				end
				2, 3: begin
					span = $urandom;
				end
				default: begin
					span = shadow_period + 32'(offset);
				end
			endcase
			w.timestamp = shadow_prev_time + span;
		end
		return w;
	endfunction

	// Offer one word, idling first as the phase asks, and hold it until the block
	// takes it. Entered and left at a clock edge, so a follow-on word keeps valid
	// high without a drop in between.
	task automatic send_word(input sample_t w, input bit typed, input reading_t typed_want);
		reading_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= w.kind;
		timestamp <= w.timestamp;
		bin_index <= w.bin_index;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_reading(w);
		awaited_readings.push_back(typed ? typed_want : predicted);
	endtask

	// Drop valid right at the accepting edge and wait for every reading to land.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (awaited_readings.size() != 0)
			@(posedge clk);
	endtask

	// One phase: drain, write the period while idle, lead in with a zero interval
	// and an exact one, then random words under the given idling, stalls and hold-off.
	task automatic run_phase(input logic [31:0] period, input int unsigned send_pct,
	                         input int unsigned stall_pct, input bit squeeze);
		drain_block();
		nominal_period_wr <= 1'b1;
		nominal_period    <= period;
		@(posedge clk);
		nominal_period_wr <= 1'b0;
		shadow_period  = period;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		if (squeeze)
			hold_request = 1'b1;
		send_word('{KIND_TICK, shadow_prev_time, 6'd0}, 1'b0, '0);
		send_word('{KIND_TICK, shadow_prev_time + period, 6'd63}, 1'b0, '0);
		repeat (PHASE_WORDS)
			send_word(pick_word(), 1'b0, '0);
	endtask

	task automatic flag_field(input string field, input logic [31:0] want,
	                          input logic [31:0] got);
		fault_count++;
		if (fault_count <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
	endtask

	// Receiver: check each accepted result word against the oldest expected reading,
	// then pick the stall for the next cycle.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_readings.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_CAP)
					$display("%0t: result word with none expected, got %h %h %h %h",
					         $time, jitter_valid, jitter, max_jitter, bin_count);
			end else begin
				want = awaited_readings.pop_front();
				if (jitter_valid !== want.jitter_valid)
					flag_field("jitter_valid", 32'(want.jitter_valid), 32'(jitter_valid));
				if (jitter !== want.jitter)
					flag_field("jitter", 32'(want.jitter), 32'(jitter));
				if (max_jitter !== want.max_jitter)
					flag_field("max_jitter", 32'(want.max_jitter), 32'(max_jitter));
				if (bin_count !== want.bin_count)
					flag_field("bin_count", want.bin_count, bin_count);
			end
		end
		out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
	end

	// Long hold-off, counted here, while the sender keeps offering words
	initial begin
		forever begin
			wait (hold_request);
			hold_request = 1'b0;
			out_hold <= 1'b1;
			repeat (HOLD_CYCLES)
				@(posedge clk);
			out_hold <= 1'b0;
		end
	end

	initial begin
		shadow_period    = NOMINAL_RESET;
		shadow_prev_time = 32'd0;
		shadow_seen_tick = 1'b0;
		shadow_worst     = 30'd0;
		foreach (shadow_bins[i])
			shadow_bins[i] = 32'd0;

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed opening under the reset period
		foreach (opening_rows[i])
			send_word(opening_rows[i].word, opening_rows[i].checked, opening_rows[i].want);

		// walk the period through its extremes and a few middle values
		run_phase(32'd40000,      0,  0,  1'b0);
		run_phase(32'd1,          62, 0,  1'b0);
		run_phase(32'hFFFF_FFFF,  0,  62, 1'b0);
		run_phase($urandom | 32'd1, 29, 29, 1'b0);
		run_phase(32'd8,          0,  0,  1'b1);
		run_phase(32'h8000_0000,  29, 29, 1'b0);

		drain_block();
		// let any stray result word surface before the verdict
		repeat (SETTLE_EDGES)
			@(posedge clk);
		if (fault_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
